[rtl/box_intersection_over_union_assert.svh]
// assertion helpers for the top-level rtl, clocked on clk and quiet during rst
`ifndef BOX_INTERSECTION_OVER_UNION_ASSERT_SVH
`define BOX_INTERSECTION_OVER_UNION_ASSERT_SVH

// same-cycle implication
`define BIOU_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BIOU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/biou_pkg.sv]
`default_nettype none

package biou_pkg;

  localparam int FIELD_W     = 16;
  localparam int NUM_COORDS  = 8;
  localparam int RATIO_W     = 17;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 24;

  // coordinate slots in the input beat
  localparam int IDX_AL = 0;
  localparam int IDX_AT = 1;
  localparam int IDX_AR = 2;
  localparam int IDX_AB = 3;
  localparam int IDX_BL = 4;
  localparam int IDX_BT = 5;
  localparam int IDX_BR = 6;
  localparam int IDX_BB = 7;

  typedef logic [NUM_COORDS-1:0][FIELD_W-1:0] coords_t;

  typedef struct packed {
    logic zero;   // result forced to zero
    logic inval;  // union not positive, boxes not disjoint
  } area_flags_t;

endpackage

`default_nettype wire

[rtl/box_intersection_over_union.sv]
// datapath: area stages, then divider stages, then the output register
// throughput: one box pair per cycle when not stalled, set by a fully pipelined
//   datapath, one stage per quotient bit, the output register as last stage
// a stalled output beat freezes the whole pipeline, nothing is dropped
// reset: synchronous active-high rst clears all valid bits, no state beyond that
`default_nettype none
`include "box_intersection_over_union_assert.svh"

module box_intersection_over_union #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom
  input  logic [biou_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // overlap_ratio[16:0], zero fill
  output logic [biou_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // union_invalid
  output logic                               m_axis_tuser
);
  import biou_pkg::*;

  localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int AW = 2 * CW;
  localparam int SW = AW + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int RW = (QW > RATIO_W) ? QW : RATIO_W;
  localparam logic [QW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic                 adv;
  coords_t              coords;
  logic                 area_v;
  logic [AW-1:0]        area_inter;
  logic [SW-1:0]        area_den;
  area_flags_t          area_flags;
  logic                 div_v;
  logic [FRAC_BITS-1:0] div_q;
  logic                 div_sat;
  area_flags_t          div_flags;
  logic [QW-1:0]        ratio;
  logic [RW-1:0]        ratio_ext;
  logic [RATIO_W-1:0]   ratio_out;
  logic                 out_inval;

  // whole pipeline moves unless a finished beat is held at the output
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign coords        = s_axis_tdata;

  biou_area #(
    .CW (CW),
    .AW (AW),
    .SW (SW)
  ) u_area (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_axis_tvalid),
    .coords    (coords),
    .out_valid (area_v),
    .inter     (area_inter),
    .den       (area_den),
    .flags     (area_flags)
  );

  biou_div #(
    .AW        (AW),
    .SW        (SW),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (area_v),
    .num       (area_inter),
    .den       (area_den),
    .in_flags  (area_flags),
    .out_valid (div_v),
    .quo       (div_q),
    .sat       (div_sat),
    .out_flags (div_flags)
  );

  always_comb begin
    if (div_flags.zero) begin
      ratio = '0;
    end else if (div_sat) begin
      ratio = ONE;
    end else begin
      ratio = {1'b0, div_q};
    end
  end

  assign ratio_ext = RW'(ratio);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ratio_out <= ratio_ext[RATIO_W-1:0];
      out_inval <= div_flags.inval;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - RATIO_W){1'b0}}, ratio_out};
  assign m_axis_tuser = out_inval;

  `BIOU_ASSERT_NOW(a_inval_zero, m_axis_tvalid && m_axis_tuser, ratio_out == '0, "invalid union with nonzero ratio")
  `BIOU_ASSERT_NEXT(a_stall_holds, !s_axis_tready, m_axis_tvalid, "input stalled with no beat held at output")
  `BIOU_ASSERT_NEXT(a_div_to_out, div_v && adv, m_axis_tvalid, "finished beat lost before output register")

endmodule

`default_nettype wire

[rtl/biou_area.sv]
`default_nettype none

module biou_area #(
  parameter int CW = 16,
  parameter int AW = 2 * CW,
  parameter int SW = AW + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  biou_pkg::coords_t    coords,
  output logic                 out_valid,
  output logic [AW-1:0]        inter,
  output logic [SW-1:0]        den,
  output biou_pkg::area_flags_t flags
);
  import biou_pkg::*;

  logic [CW-1:0] al, at, ar, ab, bl, bt, br, bb;
  logic [CW-1:0] ix0, iy0, ix1, iy1;
  logic          nxa, nya, nxb, nyb;

  // stage 1: corner differences
  logic          v1, disj1, asg1, bsg1;
  logic [CW-1:0] idx1, idy1, adx1, ady1, bdx1, bdy1;
  // stage 2: areas
  logic          v2, disj2, aneg2, bneg2;
  logic [AW-1:0] inter2, amag2, bmag2;
  // stage 3: positive and negative sums of the union
  logic          v3, disj3;
  logic [AW-1:0] inter3;
  logic [SW-1:0] pos3, neg3;
  // stage 4: union
  logic          v4;
  logic [AW-1:0] inter4;
  logic [SW-1:0] den4;
  area_flags_t   flags4;

  assign al = coords[IDX_AL][CW-1:0];
  assign at = coords[IDX_AT][CW-1:0];
  assign ar = coords[IDX_AR][CW-1:0];
  assign ab = coords[IDX_AB][CW-1:0];
  assign bl = coords[IDX_BL][CW-1:0];
  assign bt = coords[IDX_BT][CW-1:0];
  assign br = coords[IDX_BR][CW-1:0];
  assign bb = coords[IDX_BB][CW-1:0];

  assign ix0 = (al > bl) ? al : bl;
  assign iy0 = (at > bt) ? at : bt;
  assign ix1 = (ar < br) ? ar : br;
  assign iy1 = (ab < bb) ? ab : bb;

  assign nxa = ar < al;
  assign nya = ab < at;
  assign nxb = br < bl;
  assign nyb = bb < bt;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      disj1 <= (ix1 < ix0) || (iy1 < iy0);
      idx1  <= ix1 - ix0;
      idy1  <= iy1 - iy0;
      adx1  <= nxa ? (al - ar) : (ar - al);
      ady1  <= nya ? (at - ab) : (ab - at);
      bdx1  <= nxb ? (bl - br) : (br - bl);
      bdy1  <= nyb ? (bt - bb) : (bb - bt);
      asg1  <= nxa ^ nya;
      bsg1  <= nxb ^ nyb;

      disj2  <= disj1;
      inter2 <= AW'(idx1) * AW'(idy1);
      amag2  <= AW'(adx1) * AW'(ady1);
      bmag2  <= AW'(bdx1) * AW'(bdy1);
      // a zero area counts as positive
      aneg2  <= asg1 && (|adx1) && (|ady1);
      bneg2  <= bsg1 && (|bdx1) && (|bdy1);

      disj3  <= disj2;
      inter3 <= inter2;
      pos3   <= (aneg2 ? '0 : SW'(amag2)) + (bneg2 ? '0 : SW'(bmag2));
      neg3   <= SW'(inter2) + (aneg2 ? SW'(amag2) : '0) + (bneg2 ? SW'(bmag2) : '0);

      inter4       <= inter3;
      den4         <= pos3 - neg3;
      flags4.zero  <= disj3 || (pos3 <= neg3);
      flags4.inval <= !disj3 && (pos3 <= neg3);
    end
  end

  assign out_valid = v4;
  assign inter     = inter4;
  assign den       = den4;
  assign flags     = flags4;

endmodule

`default_nettype wire

[rtl/biou_div.sv]
`default_nettype none

module biou_div #(
  parameter int AW        = 32,
  parameter int SW        = AW + 2,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [AW-1:0]         num,
  input  logic [SW-1:0]         den,
  input  biou_pkg::area_flags_t in_flags,
  output logic                  out_valid,
  output logic [FRAC_BITS-1:0]  quo,
  output logic                  sat,
  output biou_pkg::area_flags_t out_flags
);
  import biou_pkg::*;

  // one restoring step per stage, quotient msb first
  logic [FRAC_BITS-1:0]                vld;
  logic [FRAC_BITS-1:0]                sat_r;
  logic [FRAC_BITS-1:0][SW-1:0]        rem;
  logic [FRAC_BITS-1:0][SW-1:0]        den_r;
  logic [FRAC_BITS-1:0][FRAC_BITS-1:0] q;
  area_flags_t [FRAC_BITS-1:0]         flg;

  genvar k;
  generate
    for (k = 0; k < FRAC_BITS; k++) begin : g_step
      logic [SW-1:0]        rem_in, den_in, shifted;
      logic [FRAC_BITS-1:0] q_in;
      logic                 v_in, sat_in;
      area_flags_t          flg_in;
      logic                 ge;

      if (k == 0) begin : g_first
        assign rem_in = SW'(num);
        assign den_in = den;
        assign q_in   = '0;
        assign v_in   = in_valid;
        assign flg_in = in_flags;
        assign sat_in = SW'(num) >= den;
      end else begin : g_rest
        assign rem_in = rem[k-1];
        assign den_in = den_r[k-1];
        assign q_in   = q[k-1];
        assign v_in   = vld[k-1];
        assign flg_in = flg[k-1];
        assign sat_in = sat_r[k-1];
      end

      assign shifted = {rem_in[SW-2:0], 1'b0};
      assign ge      = shifted >= den_in;

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (adv) begin
          vld[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          rem[k]   <= ge ? (shifted - den_in) : shifted;
          q[k]     <= {q_in[FRAC_BITS-2:0], ge};
          den_r[k] <= den_in;
          flg[k]   <= flg_in;
          sat_r[k] <= sat_in;
        end
      end
    end
  endgenerate

  assign out_valid = vld[FRAC_BITS-1];
  assign quo       = q[FRAC_BITS-1];
  assign sat       = sat_r[FRAC_BITS-1];
  assign out_flags = flg[FRAC_BITS-1];

endmodule

`default_nettype wire
